// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the maze walker RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is held.
`define LHMW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("maze walker assertion failed");

// Condition that must never be true on a clock edge out of reset.
`define LHMW_NEVER(lbl, clk, rst_n, cond) \
    `LHMW_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== rtl/lhmw_pkg.sv =====
// Package for the left-hand maze walker: register codes, the configuration
// struct, heading codes and the grid size clamp. No dependencies.
`default_nettype none

package lhmw_pkg;

    // Default grid capacity.
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Field and port widths.
    localparam int REG_W      = 7;
    localparam int STEPS_W    = 15;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;

    // Largest size value that fits a register field.
    localparam int REG_MAX = (1 << REG_W) - 1;

    // Register indexes, one 32-bit word apart.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROWS      = 3'd0,
        REG_COLS      = 3'd1,
        REG_START_ROW = 3'd2,
        REG_START_COL = 3'd3,
        REG_GOAL_ROW  = 3'd4,
        REG_GOAL_COL  = 3'd5
    } t_reg_idx;

    // Configuration as seen by the walker.
    typedef struct packed {
        logic [REG_W-1:0] rows;
        logic [REG_W-1:0] cols;
        logic [REG_W-1:0] start_row;
        logic [REG_W-1:0] start_col;
        logic [REG_W-1:0] goal_row;
        logic [REG_W-1:0] goal_col;
    } t_cfg;

    // Headings, in clockwise order.
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    // Grid size in use: zero acts as one, and the size saturates at maxv.
    function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] v,
                                                    input logic [REG_W-1:0] maxv);
        logic [REG_W-1:0] res;
        if (v == '0) begin
            res = REG_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lhmw_if.sv =====
// Valid/ready stream interfaces for the maze walker's cell input and
// result output. Depends on nothing.
`default_nettype none

// Cell stream: one grid cell per transfer.
interface lhmw_in_if;
    logic valid;
    logic ready;
    logic cell_open;
    logic last_cell;

    modport source (output valid, output cell_open, output last_cell, input ready);
    modport sink   (input valid, input cell_open, input last_cell, output ready);
endinterface

// Result stream: one walk outcome per transfer.
interface lhmw_out_if;
    logic        valid;
    logic        ready;
    logic        reached;
    logic [14:0] steps;

    modport source (output valid, output reached, output steps, input ready);
    modport sink   (input valid, input reached, input steps, output ready);
endinterface

`default_nettype wire

// ===== rtl/lhmw_cfg.sv =====
// APB-style register file for the maze walker: grid size, start and goal.
// Depends on lhmw_pkg.
`default_nettype none

module lhmw_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lhmw_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [lhmw_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [lhmw_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output lhmw_pkg::t_cfg                           o_cfg
);

    lhmw_pkg::t_cfg   r_cfg;
    lhmw_pkg::t_cfg   n_cfg;
    lhmw_pkg::t_reg_idx reg_idx;
    logic             wr_en;
    logic [lhmw_pkg::REG_W-1:0] wr_val;
    logic [lhmw_pkg::REG_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = lhmw_pkg::t_reg_idx'(paddr[lhmw_pkg::CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign wr_val  = pwdata[lhmw_pkg::REG_W-1:0];

    // Register write decode; unknown indexes are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                lhmw_pkg::REG_ROWS:      n_cfg.rows      = wr_val;
                lhmw_pkg::REG_COLS:      n_cfg.cols      = wr_val;
                lhmw_pkg::REG_START_ROW: n_cfg.start_row = wr_val;
                lhmw_pkg::REG_START_COL: n_cfg.start_col = wr_val;
                lhmw_pkg::REG_GOAL_ROW:  n_cfg.goal_row  = wr_val;
                lhmw_pkg::REG_GOAL_COL:  n_cfg.goal_col  = wr_val;
                default:                 n_cfg           = r_cfg;
            endcase
        end
    end

    // All registers come out of reset at one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows      <= lhmw_pkg::REG_W'(1);
            r_cfg.cols      <= lhmw_pkg::REG_W'(1);
            r_cfg.start_row <= lhmw_pkg::REG_W'(1);
            r_cfg.start_col <= lhmw_pkg::REG_W'(1);
            r_cfg.goal_row  <= lhmw_pkg::REG_W'(1);
            r_cfg.goal_col  <= lhmw_pkg::REG_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            lhmw_pkg::REG_ROWS:      rd_val = r_cfg.rows;
            lhmw_pkg::REG_COLS:      rd_val = r_cfg.cols;
            lhmw_pkg::REG_START_ROW: rd_val = r_cfg.start_row;
            lhmw_pkg::REG_START_COL: rd_val = r_cfg.start_col;
            lhmw_pkg::REG_GOAL_ROW:  rd_val = r_cfg.goal_row;
            lhmw_pkg::REG_GOAL_COL:  rd_val = r_cfg.goal_col;
            default:                 rd_val = '0;
        endcase
    end

    assign prdata = lhmw_pkg::CFG_DATA_W'(rd_val);
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/lhmw_map.sv =====
// Cell map store for the maze walker: load counter, one write port fed by
// the cell stream and one registered read port for the walker. Uses lhmw_pkg.
`default_nettype none

module lhmw_map #(
    parameter int DEPTH = lhmw_pkg::MAX_ROWS_DEF * lhmw_pkg::MAX_COLS_DEF,
    parameter int AW    = $clog2(lhmw_pkg::MAX_ROWS_DEF * lhmw_pkg::MAX_COLS_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic          i_wr_data,
    input  wire logic          i_wr_last,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic               o_rd_data
);

    logic          r_mem [DEPTH];
    logic [AW-1:0] r_load_idx;
    logic          r_rd_data;

    // Load position: wraps at the store depth, back to zero after the last cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
        end else if (i_wr_en) begin
            if (i_wr_last || (r_load_idx == AW'(DEPTH - 1))) begin
                r_load_idx <= '0;
            end else begin
                r_load_idx <= r_load_idx + AW'(1);
            end
        end
    end

    // Single-port write, registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_load_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/lhmw_walk.sv =====
// Walk sequencer for the maze walker: one shared multiplier for setup, one
// shared address adder for neighbor probes. Uses lhmw_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lhmw_walk #(
    parameter int MAX_ROWS = lhmw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lhmw_pkg::MAX_COLS_DEF,
    parameter int AW       = $clog2(lhmw_pkg::MAX_ROWS_DEF * lhmw_pkg::MAX_COLS_DEF)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lhmw_pkg::t_cfg                    i_cfg,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_last_cell,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_reached,
    output logic [lhmw_pkg::STEPS_W-1:0]           o_steps,
    output logic                                   o_rd_en,
    output logic [AW-1:0]                          o_rd_addr,
    input  wire logic                              i_rd_data
);

    localparam int RW      = lhmw_pkg::REG_W;
    localparam int RMAX    = (MAX_ROWS < lhmw_pkg::REG_MAX) ? MAX_ROWS : lhmw_pkg::REG_MAX;
    localparam int CMAX    = (MAX_COLS < lhmw_pkg::REG_MAX) ? MAX_COLS : lhmw_pkg::REG_MAX;
    localparam int LIM_MAX = 4 * RMAX * CMAX;
    localparam int LIM_W   = $clog2(LIM_MAX + 1);
    localparam int CW      = (LIM_W > lhmw_pkg::STEPS_W) ? LIM_W : lhmw_pkg::STEPS_W;
    localparam int PW      = 2 * RW;
    localparam int SW      = ((AW > RW) ? AW : RW) + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_ADDR,
        S_LIMIT,
        S_PROBE,
        S_CHECK,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       r_col;
    logic [AW-1:0]       r_addr;
    lhmw_pkg::t_dir      r_heading;
    logic [1:0]          r_try;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_limit;
    logic [PW-1:0]       r_prod;
    logic [RW-1:0]       r_cand_row;
    logic [RW-1:0]       r_cand_col;
    lhmw_pkg::t_dir      r_cand_dir;
    logic                r_cand_ok;
    logic [AW-1:0]       r_cand_addr;
    logic                r_reached;
    logic [lhmw_pkg::STEPS_W-1:0] r_steps;

    logic [RW-1:0]       nr;
    logic [RW-1:0]       nc;
    logic                start_in;
    logic                start_is_goal;
    logic [RW-1:0]       mul_a;
    logic [PW-1:0]       mul_p;
    lhmw_pkg::t_dir      probe_dir;
    logic                cand_ok;
    logic [RW-1:0]       cand_row;
    logic [RW-1:0]       cand_col;
    logic                step_by_row;
    logic                step_down;
    logic [SW-1:0]       add_b;
    logic [SW-1:0]       add_sum;
    logic                cand_open;
    logic                at_goal;
    logic [CW-1:0]       count_inc;

    // Grid size in use and start placement.
    assign nr = lhmw_pkg::clamp_size(i_cfg.rows, RW'(RMAX));
    assign nc = lhmw_pkg::clamp_size(i_cfg.cols, RW'(CMAX));
    assign start_in = (i_cfg.start_row != '0) && (i_cfg.start_row <= nr) &&
                      (i_cfg.start_col != '0) && (i_cfg.start_col <= nc);
    assign start_is_goal = (i_cfg.start_row == i_cfg.goal_row) &&
                           (i_cfg.start_col == i_cfg.goal_col);

    // Shared multiplier: start row offset first, then the cell count.
    assign mul_a = (r_state == S_START) ? (i_cfg.start_row - RW'(1)) : nr;
    assign mul_p = PW'(mul_a) * PW'(nc);

    // Probe direction: left of heading, then straight, right, back.
    assign probe_dir = lhmw_pkg::t_dir'(2'(r_heading + 2'd3 + r_try));

    always_comb begin
        case (probe_dir)
            lhmw_pkg::DIR_UP: begin
                cand_ok     = (r_row > RW'(1));
                cand_row    = r_row - RW'(1);
                cand_col    = r_col;
                step_by_row = 1'b1;
                step_down   = 1'b1;
            end
            lhmw_pkg::DIR_RIGHT: begin
                cand_ok     = (r_col < nc);
                cand_row    = r_row;
                cand_col    = r_col + RW'(1);
                step_by_row = 1'b0;
                step_down   = 1'b0;
            end
            lhmw_pkg::DIR_DOWN: begin
                cand_ok     = (r_row < nr);
                cand_row    = r_row + RW'(1);
                cand_col    = r_col;
                step_by_row = 1'b1;
                step_down   = 1'b0;
            end
            lhmw_pkg::DIR_LEFT: begin
                cand_ok     = (r_col > RW'(1));
                cand_row    = r_row;
                cand_col    = r_col - RW'(1);
                step_by_row = 1'b0;
                step_down   = 1'b1;
            end
            default: begin
                cand_ok     = 1'b0;
                cand_row    = r_row;
                cand_col    = r_col;
                step_by_row = 1'b0;
                step_down   = 1'b0;
            end
        endcase
    end

    // Shared address adder: a row step moves by the column count.
    assign add_b   = step_by_row ? SW'(nc) : SW'(1);
    assign add_sum = step_down ? (SW'(r_addr) - add_b) : (SW'(r_addr) + add_b);

    assign o_rd_en   = (r_state == S_PROBE) && cand_ok;
    assign o_rd_addr = add_sum[AW-1:0];

    // The start cell always counts as open, whatever the map holds.
    assign cand_open = r_cand_ok &&
                       (((r_cand_row == i_cfg.start_row) && (r_cand_col == i_cfg.start_col))
                        || i_rd_data);
    assign at_goal   = (r_cand_row == i_cfg.goal_row) && (r_cand_col == i_cfg.goal_col);
    assign count_inc = r_count + CW'(1);

    // Sequencer state and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_heading <= lhmw_pkg::DIR_UP;
            r_try     <= '0;
            r_count   <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_in_valid && i_last_cell) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_row     <= i_cfg.start_row;
                    r_col     <= i_cfg.start_col;
                    r_heading <= lhmw_pkg::DIR_UP;
                    r_try     <= '0;
                    r_count   <= '0;
                    r_prod    <= mul_p;
                    if (!start_in) begin
                        r_reached <= 1'b0;
                        r_steps   <= '0;
                        r_state   <= S_OUT;
                    end else if (start_is_goal) begin
                        r_reached <= 1'b1;
                        r_steps   <= '0;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_addr  <= AW'(r_prod + PW'(i_cfg.start_col - RW'(1)));
                    r_prod  <= mul_p;
                    r_state <= S_LIMIT;
                end
                S_LIMIT: begin
                    r_limit <= CW'({r_prod, 2'b00});
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    // The candidate address is held for the move.
                    r_cand_row  <= cand_row;
                    r_cand_col  <= cand_col;
                    r_cand_dir  <= probe_dir;
                    r_cand_ok   <= cand_ok;
                    r_cand_addr <= add_sum[AW-1:0];
                    r_state     <= S_CHECK;
                end
                S_CHECK: begin
                    if (cand_open) begin
                        r_row     <= r_cand_row;
                        r_col     <= r_cand_col;
                        r_addr    <= r_cand_addr;
                        r_heading <= r_cand_dir;
                        r_count   <= count_inc;
                        r_try     <= '0;
                        if (at_goal) begin
                            r_reached <= 1'b1;
                            r_steps   <= count_inc[lhmw_pkg::STEPS_W-1:0];
                            r_state   <= S_OUT;
                        end else if (count_inc == r_limit) begin
                            r_reached <= 1'b0;
                            r_steps   <= '0;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end else if (r_try == 2'd3) begin
                        r_reached <= 1'b0;
                        r_steps   <= '0;
                        r_state   <= S_OUT;
                    end else begin
                        r_try   <= r_try + 2'd1;
                        r_state <= S_PROBE;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign o_reached   = r_reached;
    assign o_steps     = r_steps;

    // The last cell always starts a walk, so the input closes at once.
    `LHMW_ASSERT(a_last_closes_input, i_clk, i_rst_n, (i_in_valid && o_in_ready && i_last_cell) |=> !o_in_ready)
    // A walk that misses the goal reports no moves.
    `LHMW_ASSERT(a_miss_zero_steps, i_clk, i_rst_n, (o_out_valid && !o_reached) |-> (o_steps == '0))
    // Every probe starts below the move limit.
    `LHMW_ASSERT(a_probe_under_limit, i_clk, i_rst_n, (r_state == S_PROBE) |-> (r_count < r_limit))

endmodule

`default_nettype wire

// ===== rtl/left_hand_maze_walker.sv =====
// Left-hand maze walker: the cell stream loads the map, the last cell starts
// a left-hand-rule walk, one result per grid.
// Instantiates lhmw_cfg, lhmw_map and lhmw_walk; uses lhmw_pkg and lhmw_if.
//
// Usage:
//   Program rows, cols, start and goal over the APB port while the block is
//   idle (registers 0..5 at byte addresses 0, 4, ... 20; all reset to one).
//   Stream the grid's cells in row-major order on i_in, one transfer per
//   cycle. The transfer with last_cell set closes input and starts the walk.
//   The walk runs the setup states S_START, S_ADDR and S_LIMIT, then a probe
//   state and a check state for each neighbor probe, up to four probes per
//   move, and stops at the goal, at a cell with no open neighbor, or after
//   4*rows*cols moves; a start outside the grid or on the goal skips the walk.
//   Probes share the single map read port, one probe in flight at a time.
//   The result is held on o_out until the receiver takes it; input stays
//   closed while a result waits. Reset empties the walker and returns the
//   load position to the first cell; the map itself is not cleared.
`default_nettype none

module left_hand_maze_walker #(
    parameter int MAX_ROWS = lhmw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lhmw_pkg::MAX_COLS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    lhmw_in_if.sink                                i_in,
    lhmw_out_if.source                             o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lhmw_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [lhmw_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [lhmw_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lhmw_pkg::t_cfg cfg;
    logic           in_ready;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           rd_data;

    // Configuration registers.
    lhmw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Cell map, written by each accepted cell transfer.
    lhmw_map #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_in.valid && in_ready),
        .i_wr_data (i_in.cell_open),
        .i_wr_last (i_in.last_cell),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Walk sequencer.
    lhmw_walk #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_last_cell (i_in.last_cell),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_reached   (o_out.reached),
        .o_steps     (o_out.steps),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
